/* src/pli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int DIV_CNT_W  = 6;
	localparam int FRAC_W     = 16;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_CLAMP = 2'd1,
		MODE_WRAP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_EMPTY = 1'b1
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [PTR_W-1:0]   point_index;
		logic signed [31:0] point_time;
		logic signed [31:0] point_value;
		logic signed [31:0] query_time;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               status;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] bp_time;
		logic signed [31:0] bp_value;
	} bp_t;

	// shift-subtract divider request and response
	typedef struct packed {
		logic [31:0]          rem;
		logic [31:0]          dvd;
		logic [31:0]          den;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quo;
		logic [31:0]       rem;
	} div_rsp_t;

endpackage

/* src/pli_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_div
// Restoring divider, one quotient bit per cycle. Serves both the wrap
// modulo and the Q0.16 interval fraction.
// ----------------------------------------------------------------------------
module pli_div import pli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0]          rem_q;
	logic [31:0]          dvd_q;
	logic [31:0]          den_q;
	logic [FRAC_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic                 fits;

	assign trial = {rem_q, dvd_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= req.rem;
			dvd_q <= req.dvd;
			den_q <= req.den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], fits};
			if (fits) begin
				rem_q <= 32'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	assign rsp = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule

/* src/piecewise_linear_interpolator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table in one synchronous memory, clamped or periodic queries.
// ----------------------------------------------------------------------------
// Loads, MODE_NONE requests and empty-table queries: done in the cycle after the
// request, busy stays low. Queries: edge reads of the first and last entries, the
// wrap modulo (wrap mode only), an interval scan over the table, the fraction
// divider and the blend (multiply, then accumulate). One request at a time.
// The result strobe cannot be held off. Reset clears control and point_count;
// the table is undefined until written.
module piecewise_linear_interpolator_top import pli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RDF  = 9'b000000010,
		ST_RDL  = 9'b000000100,
		ST_EDGE = 9'b000001000,
		ST_MOD  = 9'b000010000,
		ST_SCAN = 9'b000100000,
		ST_FRAC = 9'b001000000,
		ST_MUL  = 9'b010000000,
		ST_ACC  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	bp_t                mem_q [MAX_POINTS];
	bp_t                rd_word_q;
	logic [PTR_W-1:0]   rd_addr;
	logic [PTR_W-1:0]   last_idx;
	logic [1:0]         mode_q;
	logic signed [31:0] key_q;
	logic signed [31:0] t0_q;
	logic signed [31:0] v0_q;
	logic signed [31:0] tend_q;
	logic               neg_q;
	bp_t                prev_q;
	logic signed [31:0] vl_q;
	logic signed [31:0] vr_q;
	logic [PTR_W-1:0]   sa_q;
	logic [PTR_W-1:0]   pa_q;
	logic               pv_q;
	logic signed [49:0] prod_q;
	logic               done_q;
	rsp_t               rsp_q;
	logic               accept;
	logic               div_go;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic signed [32:0] d_wide;
	logic [32:0]        d_mag;
	logic signed [32:0] span_wide;
	logic signed [32:0] num_wide;
	logic signed [32:0] den_wide;
	logic signed [31:0] wrapped;
	logic signed [49:0] acc_sum;

	assign accept   = start && !busy;
	assign busy     = state_q != ST_IDLE;
	assign last_idx = PTR_W'(cnt_q - CNT_W'(1));

	always_comb begin
		case (state_q)
			ST_RDL:  rd_addr = last_idx;
			ST_SCAN: rd_addr = sa_q;
			default: rd_addr = '0;
		endcase
	end

	// wrap arithmetic against the first and last breakpoints
	assign d_wide    = $signed({key_q[31], key_q}) - $signed({t0_q[31], t0_q});
	assign d_mag     = d_wide[32] ? 33'(-d_wide) : d_wide;
	assign span_wide = $signed({rd_word_q.bp_time[31], rd_word_q.bp_time})
		- $signed({t0_q[31], t0_q});
	assign wrapped   = neg_q ? ((div_rsp.rem == '0) ? tend_q : tend_q - $signed(div_rsp.rem))
		: t0_q + $signed(div_rsp.rem);

	// interval bounds: previous word is the left end, current word the right end
	assign num_wide = $signed({key_q[31], key_q})
		- $signed({prev_q.bp_time[31], prev_q.bp_time});
	assign den_wide = $signed({rd_word_q.bp_time[31], rd_word_q.bp_time})
		- $signed({prev_q.bp_time[31], prev_q.bp_time});

	assign acc_sum = ($signed({{18{vl_q[31]}}, vl_q}) <<< FRAC_W) + prod_q;

	always_comb begin
		div_go  = 1'b0;
		div_req = '{rem: '0, dvd: '0, den: '0, steps: '0};
		if (state_q == ST_EDGE && mode_q == MODE_WRAP) begin
			div_go  = !(cnt_q == CNT_W'(1) || rd_word_q.bp_time <= t0_q);
			div_req = '{rem: '0, dvd: d_mag[31:0], den: span_wide[31:0],
				steps: DIV_CNT_W'(32)};
		end else if (state_q == ST_SCAN && pv_q && rd_word_q.bp_time > key_q
				&& pa_q != '0) begin
			div_go  = 1'b1;
			div_req = '{rem: num_wide[31:0], dvd: '0, den: den_wide[31:0],
				steps: DIV_CNT_W'(FRAC_W)};
		end
	end

	pli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (accept && req.mode == MODE_LOAD) begin
			mem_q[req.point_index] <= '{bp_time: req.point_time, bp_value: req.point_value};
		end
		rd_word_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_we) begin
			cnt_q <= (cfg_wdata > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			pv_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((req.mode == MODE_CLAMP || req.mode == MODE_WRAP)
								&& cnt_q != '0) begin
							state_q <= ST_RDF;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_RDF:  state_q <= ST_RDL;
				ST_RDL:  state_q <= ST_EDGE;
				ST_EDGE: begin
					pv_q <= 1'b0;
					if (mode_q == MODE_CLAMP) begin
						if (key_q >= rd_word_q.bp_time || key_q <= t0_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end else if (div_go) begin
						state_q <= ST_MOD;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MOD: begin
					pv_q <= 1'b0;
					if (div_rsp.done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pv_q <= 1'b1;
					if (pv_q) begin
						if (rd_word_q.bp_time > key_q) begin
							if (pa_q == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_FRAC;
							end
						end else if (pa_q == last_idx) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FRAC: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q <= req.mode;
				key_q  <= req.query_time;
				rsp_q  <= '{result_value: '0,
					status: ((req.mode == MODE_CLAMP || req.mode == MODE_WRAP)
						&& cnt_q == '0) ? STATUS_EMPTY : STATUS_OK};
			end
			ST_RDL: begin
				t0_q <= rd_word_q.bp_time;
				v0_q <= rd_word_q.bp_value;
			end
			ST_EDGE: begin
				tend_q <= rd_word_q.bp_time;
				neg_q  <= d_wide[32];
				sa_q   <= '0;
				if (mode_q == MODE_CLAMP && key_q >= rd_word_q.bp_time) begin
					rsp_q.result_value <= rd_word_q.bp_value;
				end else begin
					rsp_q.result_value <= v0_q;
				end
			end
			ST_MOD: begin
				sa_q <= '0;
				if (div_rsp.done) begin
					key_q <= wrapped;
				end
			end
			ST_SCAN: begin
				// issue the next address while the last one's word is compared
				sa_q   <= sa_q + 1'b1;
				pa_q   <= sa_q;
				prev_q <= rd_word_q;
				if (pv_q) begin
					rsp_q.result_value <= rd_word_q.bp_value;
					vl_q <= prev_q.bp_value;
					vr_q <= rd_word_q.bp_value;
				end
			end
			ST_FRAC: begin
				prod_q <= 50'(($signed({vr_q[31], vr_q}) - $signed({vl_q[31], vl_q}))
					* $signed({1'b0, div_rsp.quo}));
			end
			ST_ACC: begin
				rsp_q.result_value <= acc_sum[47:16];
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (rsp.result_value == '0))
		else $error("empty-table status with nonzero value");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == MODE_CLAMP || req.mode == MODE_WRAP) && cnt_q != '0)
		|=> busy) else $error("query on loaded table did not go busy");
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_MOD || state_q == ST_FRAC))
		else $error("divider finished outside a wait state");
`endif

endmodule
